>>> rtl/capture_period_ema_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the capture period tracker
// Concurrent checks are clocked on aclk and are off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef CAPTURE_PERIOD_EMA_TRACKER_TOP_MACROS_SVH
`define CAPTURE_PERIOD_EMA_TRACKER_TOP_MACROS_SVH

// An implication or expression that must hold at every clock edge.
`define CPET_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// An expression that must hold in the cycle after a trigger.
`define CPET_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/cpet_pkg.sv
// ----------------------------------------------------------------------------
// cpet_pkg
// Types and constants shared by the capture period tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cpet_pkg;

    localparam int ALPHA_W   = 16;
    localparam int TB_W      = 28;
    localparam int STAMP_W   = 32;
    localparam int AVG_W     = 48;
    localparam int FRAC_W    = 16;
    localparam int NUM_W     = 59;
    localparam int DIV_CNT_W = 6;
    localparam int SPLIT_W   = 24;
    localparam int MUL_A_W   = 28;
    localparam int MUL_B_W   = 16;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int FILL_O_W  = 9;
    localparam int OUT_W     = 192;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd1311;
    localparam logic [TB_W-1:0]    TB_RESET    = 28'd99840000;

    typedef enum logic [1:0] {
        REQ_CAPTURE = 2'd0,
        REQ_SERVICE = 2'd1,
        REQ_RESTART = 2'd2
    } req_e;

    typedef enum logic {
        REG_ALPHA    = 1'b0,
        REG_TIMEBASE = 1'b1
    } reg_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN,
        ST_READ,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_APPLY,
        ST_RATE_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic exec;
        logic read_wb;
        logic mul_lo;
        logic mul_hi;
        logic apply;
        logic rate_mul;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic       in_fire;
        logic [1:0] req;
        logic       started;
        logic       empty;
        logic       seeded;
        logic       div_done;
        logic       out_busy;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/cpet_ram.sv
// ----------------------------------------------------------------------------
// cpet_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpet_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/cpet_div.sv
// ----------------------------------------------------------------------------
// cpet_div
// Restoring divider, one quotient bit per cycle, saturated 32-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module cpet_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [cpet_pkg::NUM_W-1:0]    num,
    input  wire logic [cpet_pkg::AVG_W-1:0]    den,
    output logic                               done,
    output logic [31:0]                        quot
);
    import cpet_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [AVG_W-1:0]     rem_reg, rem_next;
    logic [AVG_W-1:0]     den_reg, den_next;
    logic [NUM_W-1:0]     sh_reg, sh_next;
    logic [NUM_W-1:0]     q_reg, q_next;
    logic [AVG_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, sh_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(NUM_W);
            rem_next  = '0;
            den_next  = den;
            sh_next   = num;
            q_next    = '0;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so it fits the divisor width.
            rem_next = fits ? AVG_W'(trial - {1'b0, den_reg}) : trial[AVG_W-1:0];
            q_next   = {q_reg[NUM_W-2:0], fits};
            sh_next  = {sh_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = (|q_reg[NUM_W-1:32]) ? 32'hFFFF_FFFF : q_reg[31:0];

endmodule

`default_nettype wire

>>> rtl/cpet_ctrl.sv
// ----------------------------------------------------------------------------
// cpet_ctrl
// Sequencer that steps one item through exec, drain, rate and report.
// ----------------------------------------------------------------------------
`default_nettype none

module cpet_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cpet_pkg::status_t sts,
    output cpet_pkg::cmd_t         cmd
);
    import cpet_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (sts.in_fire) state_next = ST_EXEC;
            ST_EXEC: begin
                if (sts.req == REQ_SERVICE && sts.started) state_next = ST_DRAIN;
                else state_next = ST_RATE_MUL;
            end
            ST_DRAIN:     state_next = sts.empty ? ST_RATE_MUL : ST_READ;
            // An unseeded average takes the first period as it is.
            ST_READ:      state_next = sts.seeded ? ST_MUL_LO : ST_DRAIN;
            ST_MUL_LO:    state_next = ST_MUL_HI;
            ST_MUL_HI:    state_next = ST_APPLY;
            ST_APPLY:     state_next = ST_DRAIN;
            ST_RATE_MUL:  state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (sts.div_done) state_next = ST_DONE;
            ST_DONE:      if (!sts.out_busy) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:      cmd.in_ready  = 1'b1;
            ST_EXEC:      cmd.exec      = 1'b1;
            ST_READ:      cmd.read_wb   = 1'b1;
            ST_MUL_LO:    cmd.mul_lo    = 1'b1;
            ST_MUL_HI:    cmd.mul_hi    = 1'b1;
            ST_APPLY:     cmd.apply     = 1'b1;
            ST_RATE_MUL:  cmd.rate_mul  = 1'b1;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DONE:      cmd.out_load  = !sts.out_busy;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/capture_period_ema_tracker_top.sv
// Each item steps through exec, rate multiply, divider start, divide wait and report;
// no new item is taken until the last report is loaded. A service item on a running
// queue first drains each stored period (read, low and high multiply, apply; only a
// read for the period that seeds the average). A stalled result holds s_tready low.
// Reset (aresetn low, synchronous) clears control state, pointers and counters and
// reloads the register defaults; the period store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// capture_period_ema_tracker_top
// Capture period FIFO, moving-average period and rate in Hz times 100.
// ----------------------------------------------------------------------------
`default_nettype none

`include "capture_period_ema_tracker_top_macros.svh"

module capture_period_ema_tracker_top #(
    parameter int QUEUE_DEPTH = 256,
    parameter int EDGE_STRIDE = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] capture_time
    input  wire logic [1:0]   s_tuser,   // [1:0] req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [47:0] smoothed_period, [79:48] rate_x100, [111:80] last_period,
    // [143:112] captures_seen, [175:144] overruns_seen, [184:176] queue_fill,
    // [185] average_valid, [186] queue_running, [191:187] zero
    output logic [191:0]      m_tdata,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_addr,
    input  wire logic [27:0]  cfg_wdata
);
    import cpet_pkg::*;

    localparam int PTR_SPAN = 2 * QUEUE_DEPTH;
    localparam int PTR_W    = $clog2(PTR_SPAN);
    localparam int IDX_W    = $clog2(QUEUE_DEPTH);
    localparam int RATE_K   = EDGE_STRIDE * 100;

    cmd_t    cmd;
    status_t sts;

    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [TB_W-1:0]    tb_reg, tb_next;
    logic [1:0]         req_reg, req_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [STAMP_W-1:0] prev_reg, prev_next;
    logic               have_prev_reg, have_prev_next;
    logic [31:0]        capt_reg, capt_next;
    logic [31:0]        last_reg, last_next;
    logic               started_reg, started_next;
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [31:0]        ovr_reg, ovr_next;
    logic               seeded_reg, seeded_next;
    logic [AVG_W-1:0]   avg_reg, avg_next;
    logic [AVG_W-1:0]   mag_reg, mag_next;
    logic               up_reg, up_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    logic [PTR_W:0]       fill_wrap;
    logic [PTR_W-1:0]     fill;
    logic                 full;
    logic [PTR_W+8:0]     fill_ext;
    logic [STAMP_W-1:0]   period;
    logic                 ram_we;
    logic [STAMP_W-1:0]   ram_rdata;
    logic [AVG_W-1:0]     target;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [63:0]          step_sum;
    logic [AVG_W-1:0]     step;
    logic                 div_done;
    logic [31:0]          div_quot;
    logic [31:0]          rate;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(PTR_SPAN - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    // A pointer runs over twice the depth; the entry is the pointer folded once.
    function automatic logic [IDX_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] folded;
        folded = (p >= PTR_W'(QUEUE_DEPTH)) ? PTR_W'(p - PTR_W'(QUEUE_DEPTH)) : p;
        return folded[IDX_W-1:0];
    endfunction

    assign fill_wrap = (wptr_reg >= rptr_reg) ? {1'b0, wptr_reg} - {1'b0, rptr_reg}
                     : {1'b0, wptr_reg} + (PTR_W+1)'(PTR_SPAN) - {1'b0, rptr_reg};
    assign fill      = fill_wrap[PTR_W-1:0];
    assign full      = fill >= PTR_W'(QUEUE_DEPTH);
    assign fill_ext  = {9'd0, fill};
    assign period    = stamp_reg - prev_reg;
    assign target    = {ram_rdata, {FRAC_W{1'b0}}};
    assign ram_we    = cmd.exec && req_reg == REQ_CAPTURE && have_prev_reg
                       && started_reg && !full;

    cpet_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ptr_idx(wptr_reg)),
        .wdata (period),
        .raddr (ptr_idx(rptr_reg)),
        .rdata (ram_rdata)
    );

    // Shared multiplier: alpha times a 24-bit slice of the error, or timebase
    // times the stride and percent scale.
    always_comb begin
        mul_a = tb_reg;
        mul_b = MUL_B_W'(RATE_K);
        if (cmd.mul_lo) begin
            mul_a = MUL_A_W'(mag_reg[SPLIT_W-1:0]);
            mul_b = alpha_reg;
        end else if (cmd.mul_hi) begin
            mul_a = MUL_A_W'(mag_reg[AVG_W-1:SPLIT_W]);
            mul_b = alpha_reg;
        end
    end

    assign step_sum = {prod_reg[39:0], {SPLIT_W{1'b0}}} + {24'd0, acc_reg[39:0]}
                      + 64'd32768;
    assign step     = step_sum[63:FRAC_W];

    cpet_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     ({prod_reg[NUM_W-FRAC_W-1:0], {FRAC_W{1'b0}}}),
        .den     (avg_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign rate = (seeded_reg && avg_reg != '0) ? div_quot : 32'd0;

    assign sts.in_fire  = s_tvalid && cmd.in_ready;
    assign sts.req      = req_reg;
    assign sts.started  = started_reg;
    assign sts.empty    = rptr_reg == wptr_reg;
    assign sts.seeded   = seeded_reg;
    assign sts.div_done = div_done;
    assign sts.out_busy = out_valid_reg && !m_tready;

    cpet_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    always_comb begin
        alpha_next     = alpha_reg;
        tb_next        = tb_reg;
        req_next       = req_reg;
        stamp_next     = stamp_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        capt_next      = capt_reg;
        last_next      = last_reg;
        started_next   = started_reg;
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        ovr_next       = ovr_reg;
        seeded_next    = seeded_reg;
        avg_next       = avg_reg;
        mag_next       = mag_reg;
        up_next        = up_reg;
        prod_next      = mul_a * mul_b;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        if (cfg_wr_en) begin
            unique case (reg_e'(cfg_addr))
                REG_ALPHA:    alpha_next = cfg_wdata[ALPHA_W-1:0];
                REG_TIMEBASE: tb_next    = cfg_wdata;
                default:      tb_next    = tb_reg;
            endcase
        end

        if (sts.in_fire) begin
            req_next   = s_tuser;
            stamp_next = s_tdata;
        end

        if (cmd.exec) begin
            unique case (req_reg)
                REQ_CAPTURE: begin
                    capt_next = capt_reg + 1'b1;
                    if (have_prev_reg) begin
                        last_next = period;
                        if (started_reg) begin
                            if (!full) wptr_next = ptr_inc(wptr_reg);
                            else ovr_next = ovr_reg + 1'b1;
                        end
                    end
                    prev_next      = stamp_reg;
                    have_prev_next = 1'b1;
                end
                REQ_SERVICE: begin
                    if (!started_reg) begin
                        // First service: drop the backlog and seed from the last period.
                        rptr_next    = wptr_reg;
                        started_next = 1'b1;
                        if (last_reg != '0) begin
                            avg_next    = {last_reg, {FRAC_W{1'b0}}};
                            seeded_next = 1'b1;
                        end
                    end
                end
                REQ_RESTART: begin
                    prev_next      = '0;
                    have_prev_next = 1'b0;
                    last_next      = '0;
                    started_next   = 1'b0;
                    rptr_next      = wptr_reg;
                    ovr_next       = '0;
                    seeded_next    = 1'b0;
                    avg_next       = '0;
                    capt_next      = '0;
                end
                default: begin
                    capt_next = capt_reg;
                end
            endcase
        end

        if (cmd.read_wb) begin
            rptr_next = ptr_inc(rptr_reg);
            if (!seeded_reg) begin
                avg_next    = target;
                seeded_next = 1'b1;
            end else begin
                up_next  = target >= avg_reg;
                mag_next = (target >= avg_reg) ? target - avg_reg : avg_reg - target;
            end
        end

        if (cmd.mul_hi) begin
            acc_next = prod_reg;
        end

        if (cmd.apply) begin
            avg_next = up_reg ? avg_reg + step : avg_reg - step;
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = {5'd0, started_reg, seeded_reg, fill_ext[FILL_O_W-1:0],
                              ovr_reg, capt_reg, last_reg, rate, avg_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg     <= ALPHA_RESET;
            tb_reg        <= TB_RESET;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            capt_reg      <= '0;
            last_reg      <= '0;
            started_reg   <= 1'b0;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            ovr_reg       <= '0;
            seeded_reg    <= 1'b0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            alpha_reg     <= alpha_next;
            tb_reg        <= tb_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            capt_reg      <= capt_next;
            last_reg      <= last_next;
            started_reg   <= started_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            ovr_reg       <= ovr_next;
            seeded_reg    <= seeded_next;
            avg_reg       <= avg_next;
            out_valid_reg <= out_valid_next;
        end
        req_reg      <= req_next;
        stamp_reg    <= stamp_next;
        mag_reg      <= mag_next;
        up_reg       <= up_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = cmd.in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `CPET_ASSERT(a_fill_bound, fill <= PTR_W'(QUEUE_DEPTH), "queue fill exceeds depth")
    `CPET_ASSERT(a_unseeded_zero, !seeded_reg |-> avg_reg == '0, "unseeded average not zero")
    `CPET_ASSERT(a_stopped_empty, !started_reg |-> rptr_reg == wptr_reg, "queue holds data before start")
    `CPET_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives capture, service and restart transfers into the period tracker and
// checks every status report against a predictor of the moving average,
// the period queue and the rate division, over several idling phases.
// ----------------------------------------------------------------------------
`default_nettype none

class period_scoreboard;
    bit [15:0] alpha;
    bit [27:0] timebase;
    bit [31:0] prev_stamp;
    bit        have_prev;
    bit [31:0] tally;
    bit [31:0] latest;
    bit        started;
    bit [8:0]  wr_ptr;
    bit [8:0]  rd_ptr;
    bit [31:0] overruns;
    bit [31:0] store [256];
    bit        seeded;
    bit [47:0] avg;
    bit [191:0] pending [$];
    int        errors;

    function new();
        alpha = 16'd1311;
        timebase = 28'd99840000;
        wr_ptr = 0;
        clear_state();
        rd_ptr = 0;
        errors = 0;
    endfunction

    function void clear_state();
        prev_stamp = 0;
        have_prev = 0;
        latest = 0;
        started = 0;
        rd_ptr = wr_ptr;
        overruns = 0;
        seeded = 0;
        avg = 0;
        tally = 0;
    endfunction

    function bit [8:0] fill();
        return wr_ptr - rd_ptr;
    endfunction

    function void smooth(bit [31:0] period);
        bit [63:0] target;
        bit [63:0] mag;
        bit [63:0] step;
        target = {16'd0, period, 16'd0};
        if (!seeded) begin
            avg = target[47:0];
            seeded = 1;
            return;
        end
        if (target >= avg) begin
            mag = target - avg;
            step = (mag * alpha + 64'd32768) >> 16;
            avg = avg + step[47:0];
        end else begin
            mag = avg - target;
            step = (mag * alpha + 64'd32768) >> 16;
            avg = avg - step[47:0];
        end
    endfunction

    function bit [31:0] rate();
        bit [63:0] num;
        bit [63:0] q;
        if (!seeded || avg == 0) return 0;
        num = 64'd16 * timebase * 64'd100 * 64'd65536;
        q = num / avg;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function void note_input(bit [1:0] req, bit [31:0] stamp);
        bit [31:0] period;
        case (req)
            cpet_pkg::REQ_CAPTURE: begin
                tally++;
                if (have_prev) begin
                    period = stamp - prev_stamp;
                    latest = period;
                    if (started) begin
                        if (fill() < 256) begin
                            store[wr_ptr[7:0]] = period;
                            wr_ptr++;
                        end else begin
                            overruns++;
                        end
                    end
                end
                prev_stamp = stamp;
                have_prev = 1;
            end
            cpet_pkg::REQ_SERVICE: begin
                if (!started) begin
                    rd_ptr = wr_ptr;
                    started = 1;
                    if (latest != 0) begin
                        avg = {latest, 16'd0};
                        seeded = 1;
                    end
                end else begin
                    while (rd_ptr != wr_ptr) begin
                        period = store[rd_ptr[7:0]];
                        rd_ptr++;
                        smooth(period);
                    end
                end
            end
            cpet_pkg::REQ_RESTART: clear_state();
            default: ;
        endcase
        pending.push_back({5'd0, started, seeded, fill(), overruns, tally, latest,
                           rate(), avg});
    endfunction

    function void check_report(bit [191:0] got);
        bit [191:0] exp;
        if (pending.size() == 0) begin
            $error("report with no expectation waiting: %h", got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got[47:0] !== exp[47:0]) begin
            $error("smoothed_period exp %h got %h", exp[47:0], got[47:0]); errors++;
        end
        if (got[79:48] !== exp[79:48]) begin
            $error("rate_x100 exp %0d got %0d", exp[79:48], got[79:48]); errors++;
        end
        if (got[111:80] !== exp[111:80]) begin
            $error("last_period exp %0d got %0d", exp[111:80], got[111:80]); errors++;
        end
        if (got[143:112] !== exp[143:112]) begin
            $error("captures_seen exp %0d got %0d", exp[143:112], got[143:112]); errors++;
        end
        if (got[175:144] !== exp[175:144]) begin
            $error("overruns_seen exp %0d got %0d", exp[175:144], got[175:144]); errors++;
        end
        if (got[184:176] !== exp[184:176]) begin
            $error("queue_fill exp %0d got %0d", exp[184:176], got[184:176]); errors++;
        end
        if (got[185] !== exp[185]) begin
            $error("average_valid exp %b got %b", exp[185], got[185]); errors++;
        end
        if (got[186] !== exp[186]) begin
            $error("queue_running exp %b got %b", exp[186], got[186]); errors++;
        end
        if (got[191:187] !== 5'd0) begin
            $error("pad bits exp 0 got %b", got[191:187]); errors++;
        end
    endfunction
endclass

module tb_top;
    import cpet_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    wire          s_tready;
    logic [31:0]  s_tdata;
    logic [1:0]   s_tuser;
    wire          m_tvalid;
    logic         m_tready;
    wire  [191:0] m_tdata;
    logic         cfg_wr_en;
    logic         cfg_addr;
    logic [27:0]  cfg_wdata;

    period_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    bit [31:0] stamp_now;

    capture_period_ema_tracker_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0; #1;
        aclk = 1'b1; #1;
    end

    // Receiver: ready is chosen at each falling edge, reports sampled at the rising one.
    always @(negedge aclk) begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_report(m_tdata);
    end

    // Inputs are set with blocking assignments at the falling edge, so back-to-back
    // calls may set a signal twice in one time step.
    task automatic send_item(input bit [1:0] req, input bit [31:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = stamp;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(req, stamp);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input reg_e idx, input bit [27:0] value);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        if (idx == REG_ALPHA) sb.alpha = value[15:0];
        else sb.timebase = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    // A capture whose period is usually near nominal, sometimes anything.
    task automatic send_capture();
        bit [31:0] delta;
        case ($urandom_range(9))
            0: delta = $urandom;
            1: delta = $urandom_range(3);
            default: delta = 32'd16000 + $urandom_range(400);
        endcase
        stamp_now = stamp_now + delta;
        send_item(REQ_CAPTURE, stamp_now);
    endtask

    task automatic random_phase(input int count);
        int kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(99);
            if (kind < 80) send_capture();
            else if (kind < 95) send_item(REQ_SERVICE, $urandom);
            else if (kind < 98) send_item(REQ_RESTART, $urandom);
            else send_item(2'd3, $urandom);
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = 1'b0;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        stamp_now = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: service before any period, first capture, wrapping periods.
        send_item(REQ_SERVICE, 32'hFFFF_FFFF);
        send_item(REQ_CAPTURE, 32'hFFFF_FFF0);
        send_item(REQ_CAPTURE, 32'h0000_0010);
        send_item(2'd3, 32'h1234_5678);
        send_item(REQ_RESTART, 32'd0);
        send_item(REQ_CAPTURE, 32'd5);
        send_item(REQ_SERVICE, 32'd0);
        send_item(REQ_CAPTURE, 32'd100);
        send_item(REQ_CAPTURE, 32'd101);
        send_item(REQ_CAPTURE, 32'h8000_0000);
        send_item(REQ_SERVICE, 32'd0);
        send_item(REQ_CAPTURE, 32'h8000_0000);
        send_item(REQ_SERVICE, 32'd0);
        send_item(REQ_RESTART, 32'hFFFF_FFFF);
        // Overflow the queue: 260 periods after start.
        send_item(REQ_CAPTURE, 32'd0);
        send_item(REQ_CAPTURE, 32'd3);
        send_item(REQ_SERVICE, 32'd0);
        stamp_now = 3;
        for (int i = 0; i < 260; i++) send_capture();
        send_item(REQ_SERVICE, 32'd0);
        wait_drained();

        // Extreme registers; alpha of zero via write data wider than the field.
        write_reg(REG_ALPHA, 28'hFFF_FFFF);
        write_reg(REG_TIMEBASE, 28'd1);
        random_phase(150);
        wait_drained();
        write_reg(REG_ALPHA, 28'h001_0000);
        write_reg(REG_TIMEBASE, 28'd200000000);
        random_phase(150);
        wait_drained();
        write_reg(REG_ALPHA, 28'd1);
        write_reg(REG_TIMEBASE, 28'd0);
        random_phase(150);
        wait_drained();
        write_reg(REG_ALPHA, 28'h000_FFFF);
        write_reg(REG_TIMEBASE, 28'hFFF_FFFF);
        random_phase(150);
        wait_drained();
        write_reg(REG_ALPHA, 28'd1311);
        write_reg(REG_TIMEBASE, 28'd99840000);

        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(negedge aclk);
                hold_off = 1'b0;
            end
            random_phase(20);
        join

        send_idle_pct = 88;
        random_phase(250);
        send_idle_pct = 0;
        recv_stall_pct = 88;
        random_phase(250);
        wait_drained();
        send_idle_pct = 38;
        recv_stall_pct = 38;
        write_reg(REG_ALPHA, 28'd40000);
        random_phase(250);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(250);

        wait_drained();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end
endmodule

`default_nettype wire
